FILE: src/wss_pkg.sv
// Shared types and constants for the module wake/sleep sequencer.
// No dependencies; imported by every module of the block.
package wss_pkg;

  // Default width of the pulse and poll counters.
  localparam int unsigned COUNTER_BITS_DEF = 4;

  // Configuration register widths, indexes and reset values.
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ATT_W      = 3;
  localparam int unsigned REG_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_ATTEMPTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_POLLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_POLLS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS   = 2'd3;

  localparam logic [ATT_W-1:0] WAKE_ATTEMPTS_RST = 3'd3;
  localparam logic [REG_W-1:0] WAKE_POLLS_RST    = 4'd10;
  localparam logic [REG_W-1:0] SLEEP_POLLS_RST   = 4'd15;
  localparam logic [REG_W-1:0] PULSE_TICKS_RST   = 4'd1;

  // Event codes carried in the mode field; the last code means no event.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WAKE  = 2'd1;
  localparam logic [1:0] MODE_SLEEP = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Sequencer phase.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PULSE = 2'd1,
    PH_POLL  = 2'd2
  } phase_t;

  // Input beat.
  typedef struct packed {
    logic [1:0] mode;
    logic       awake_level;
  } cmd_t;

  // Result beat.
  typedef struct packed {
    logic power_pin;
    logic busy_res;
    logic done_res;
    logic status;
  } res_t;

endpackage

FILE: src/wss_cfg.sv
// Configuration registers of the wake/sleep sequencer and their limit clamping.
// Depends on wss_pkg.
module wss_cfg #(
  parameter int unsigned COUNTER_BITS = wss_pkg::COUNTER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wss_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [wss_pkg::ATT_W-1:0]      attempt_lim,
  output logic [COUNTER_BITS-1:0]        wake_poll_lim,
  output logic [COUNTER_BITS-1:0]        sleep_poll_lim,
  output logic [COUNTER_BITS-1:0]        pulse_lim
);
  import wss_pkg::*;

  // Common width for comparing a 4-bit register against the counter maximum.
  localparam int unsigned EXT_W = (COUNTER_BITS > REG_W) ? COUNTER_BITS : REG_W;
  localparam logic [EXT_W-1:0] CMAX_EXT = EXT_W'((1 << COUNTER_BITS) - 1);

  logic [ATT_W-1:0] wake_attempts;
  logic [REG_W-1:0] wake_polls;
  logic [REG_W-1:0] sleep_polls;
  logic [REG_W-1:0] pulse_ticks;

  // Register writes; unknown indexes cannot occur with a two-bit index.
  always_ff @(posedge clk) begin
    if (rst) begin
      wake_attempts <= WAKE_ATTEMPTS_RST;
      wake_polls    <= WAKE_POLLS_RST;
      sleep_polls   <= SLEEP_POLLS_RST;
      pulse_ticks   <= PULSE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WAKE_ATTEMPTS: wake_attempts <= cfg_data[ATT_W-1:0];
        CFG_WAKE_POLLS:    wake_polls    <= cfg_data[REG_W-1:0];
        CFG_SLEEP_POLLS:   sleep_polls   <= cfg_data[REG_W-1:0];
        CFG_PULSE_TICKS:   pulse_ticks   <= cfg_data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero count acts as one; a count above the counter range saturates.
  function automatic logic [COUNTER_BITS-1:0] clamp_cnt(input logic [REG_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (v == '0) begin
      return COUNTER_BITS'(1);
    end else if (ext > CMAX_EXT) begin
      return CMAX_EXT[COUNTER_BITS-1:0];
    end else begin
      return ext[COUNTER_BITS-1:0];
    end
  endfunction

  assign wake_poll_lim  = clamp_cnt(wake_polls);
  assign sleep_poll_lim = clamp_cnt(sleep_polls);
  assign pulse_lim      = clamp_cnt(pulse_ticks);
  assign attempt_lim    = (wake_attempts == '0) ? ATT_W'(1) : wake_attempts;

endmodule

FILE: src/wss_seq.sv
// Sequencer state and the single-pass step logic that turns one event into one result.
// Depends on wss_pkg.
module wss_seq #(
  parameter int unsigned COUNTER_BITS = wss_pkg::COUNTER_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  wss_pkg::cmd_t             cmd,
  input  logic [wss_pkg::ATT_W-1:0] attempt_lim,
  input  logic [COUNTER_BITS-1:0]   wake_poll_lim,
  input  logic [COUNTER_BITS-1:0]   sleep_poll_lim,
  input  logic [COUNTER_BITS-1:0]   pulse_lim,
  output wss_pkg::res_t             res_next
);
  import wss_pkg::*;

  phase_t                   phase, phase_next;
  logic                     going_to_sleep, going_to_sleep_next;
  logic [ATT_W-1:0]         attempt_count, attempt_count_next;
  logic [COUNTER_BITS-1:0]  poll_count, poll_count_next;
  logic [COUNTER_BITS-1:0]  pulse_count, pulse_count_next;
  logic                     power_level, power_level_next;

  logic                     is_cmd;
  logic                     want_sleep;
  logic                     in_target;
  logic [COUNTER_BITS-1:0]  pulse_inc;
  logic [COUNTER_BITS-1:0]  poll_inc;
  logic [COUNTER_BITS-1:0]  poll_lim;
  logic [ATT_W-1:0]         attempt_inc;
  logic                     done;
  logic                     status;

  // State register; it advances only on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      going_to_sleep <= 1'b0;
      attempt_count  <= '0;
      poll_count     <= '0;
      pulse_count    <= '0;
      power_level    <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      going_to_sleep <= going_to_sleep_next;
      attempt_count  <= attempt_count_next;
      poll_count     <= poll_count_next;
      pulse_count    <= pulse_count_next;
      power_level    <= power_level_next;
    end
  end

  assign is_cmd      = (cmd.mode == MODE_WAKE) || (cmd.mode == MODE_SLEEP);
  assign want_sleep  = (cmd.mode == MODE_SLEEP);
  assign pulse_inc   = pulse_count + COUNTER_BITS'(1);
  assign poll_inc    = poll_count + COUNTER_BITS'(1);
  assign attempt_inc = attempt_count + ATT_W'(1);
  assign poll_lim    = going_to_sleep ? sleep_poll_lim : wake_poll_lim;
  // The module has reached the state the running sequence aims for.
  assign in_target   = (going_to_sleep == !cmd.awake_level);

  // Next state and result for one event.
  always_comb begin
    phase_next          = phase;
    going_to_sleep_next = going_to_sleep;
    attempt_count_next  = attempt_count;
    poll_count_next     = poll_count;
    pulse_count_next    = pulse_count;
    power_level_next    = power_level;
    done                = 1'b0;
    status              = 1'b0;

    unique case (phase)
      PH_PULSE: begin
        if (cmd.mode == MODE_TICK) begin
          pulse_count_next = pulse_inc;
          if (pulse_inc == '0 || pulse_inc >= pulse_lim) begin
            power_level_next = 1'b0;
            poll_count_next  = '0;
            phase_next       = PH_POLL;
          end
        end
      end
      PH_POLL: begin
        if (cmd.mode == MODE_TICK) begin
          poll_count_next = poll_inc;
          if (in_target) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else if (poll_inc == '0 || poll_inc >= poll_lim) begin
            if (going_to_sleep) begin
              phase_next = PH_IDLE;
              done       = 1'b1;
              status     = 1'b1;
            end else begin
              attempt_count_next = attempt_inc;
              if (attempt_inc != '0 && attempt_inc < attempt_lim) begin
                // Another wake attempt: restart the power pulse.
                poll_count_next  = '0;
                pulse_count_next = '0;
                power_level_next = 1'b1;
                phase_next       = PH_PULSE;
              end else begin
                phase_next = PH_IDLE;
                done       = 1'b1;
                status     = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        // Idle, and the unused phase code, which behaves as idle.
        phase_next = PH_IDLE;
        if (is_cmd) begin
          going_to_sleep_next = want_sleep;
          if (want_sleep == !cmd.awake_level) begin
            done = 1'b1;
          end else begin
            attempt_count_next = '0;
            poll_count_next    = '0;
            pulse_count_next   = '0;
            power_level_next   = 1'b1;
            phase_next         = PH_PULSE;
          end
        end
      end
    endcase

    res_next.power_pin = power_level_next;
    res_next.busy_res  = (phase_next == PH_PULSE) || (phase_next == PH_POLL);
    res_next.done_res  = done;
    res_next.status    = status;
  end

endmodule

FILE: src/module_wake_sleep_sequencer.sv
// Top level of the module wake/sleep sequencer: handshake and result register.
// Depends on wss_pkg, wss_cfg and wss_seq.
//
// Usage: each beat on the cmd channel is one event (a tick, a wake command or a
// sleep command) with the sampled awake pin level. Every accepted beat yields
// exactly one beat on the res channel, carrying the power pin level, busy,
// done and timeout status after that event.
// The result of an accepted beat is registered and valid from the next cycle on.
// Throughput is one beat per cycle while the receiver does not stall; the step logic is a few
// counter compares between the state registers and the result register.
// When the receiver stalls, the result register holds its beat and cmd_ready
// stays high only if that beat is taken in the same cycle, so no beat is lost.
// The cfg port writes one register per cycle with no wait; write it only while
// no result is outstanding.
// Synchronous reset returns the sequencer to idle with the power pin low,
// empties the result register and loads the default register values.
module module_wake_sleep_sequencer #(
  parameter int unsigned COUNTER_BITS = wss_pkg::COUNTER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  wss_pkg::cmd_t                  cmd,
  output logic                           res_valid,
  input  logic                           res_ready,
  output wss_pkg::res_t                  res,
  input  logic                           cfg_we,
  input  logic [wss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wss_pkg::*;

  logic [ATT_W-1:0]        attempt_lim;
  logic [COUNTER_BITS-1:0] wake_poll_lim;
  logic [COUNTER_BITS-1:0] sleep_poll_lim;
  logic [COUNTER_BITS-1:0] pulse_lim;
  logic                    accept;
  res_t                    res_next;

  wss_cfg #(.COUNTER_BITS(COUNTER_BITS)) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .attempt_lim   (attempt_lim),
    .wake_poll_lim (wake_poll_lim),
    .sleep_poll_lim(sleep_poll_lim),
    .pulse_lim     (pulse_lim)
  );

  wss_seq #(.COUNTER_BITS(COUNTER_BITS)) u_seq (
    .clk           (clk),
    .rst           (rst),
    .step          (accept),
    .cmd           (cmd),
    .attempt_lim   (attempt_lim),
    .wake_poll_lim (wake_poll_lim),
    .sleep_poll_lim(sleep_poll_lim),
    .pulse_lim     (pulse_lim),
    .res_next      (res_next)
  );

  // A new beat enters when the result register is empty or being drained.
  assign cmd_ready = !res_valid || res_ready;
  assign accept    = cmd_valid && cmd_ready;

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Every accepted beat leaves a result waiting on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted beat did not produce a result");

  // A timeout is reported only together with done.
  a_status_needs_done: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res.status || res.done_res))
    else $error("status set without done");

  // The power pin is driven only while a sequence runs.
  a_power_only_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.power_pin) |-> res.busy_res)
    else $error("power pin high while idle");

  // A finishing step always leaves the sequencer idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.done_res && res.busy_res))
    else $error("done reported while still busy");
`endif

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the module wake/sleep sequencer.
// Depends on wss_pkg and module_wake_sleep_sequencer; a built-in predictor checks every result beat.
`timescale 1ns / 100ps

module testbench;
  import wss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_ready;
  cmd_t                  cmd = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  res_t                  res;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted sequencer state and register copies.
  phase_t     seq_phase;
  logic       seq_to_sleep;
  logic [2:0] seq_attempts;
  logic [3:0] seq_polls;
  logic [3:0] seq_pulses;
  logic       seq_power;
  logic [2:0] reg_attempts;
  logic [3:0] reg_wake_polls;
  logic [3:0] reg_sleep_polls;
  logic [3:0] reg_pulse_ticks;

  res_t        pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;

  module_wake_sleep_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with a 4 ns period.
  initial begin
    forever begin
      #2 clk = ~clk;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // A zero count acts as one.
  function automatic logic [3:0] count_limit(input logic [3:0] v);
    return (v == 4'd0) ? 4'd1 : v;
  endfunction

  function automatic logic [2:0] attempt_limit(input logic [2:0] v);
    return (v == 3'd0) ? 3'd1 : v;
  endfunction

  function automatic void sequencer_reset();
    seq_phase       = PH_IDLE;
    seq_to_sleep    = 1'b0;
    seq_attempts    = '0;
    seq_polls       = '0;
    seq_pulses      = '0;
    seq_power       = 1'b0;
    reg_attempts    = WAKE_ATTEMPTS_RST;
    reg_wake_polls  = WAKE_POLLS_RST;
    reg_sleep_polls = SLEEP_POLLS_RST;
    reg_pulse_ticks = PULSE_TICKS_RST;
  endfunction

  function automatic void start_pulse();
    seq_power  = 1'b1;
    seq_pulses = '0;
    seq_phase  = PH_PULSE;
  endfunction

  // Advance the predicted sequencer by one event and return the result beat it causes.
  function automatic res_t sequencer_step(input cmd_t c);
    res_t       r;
    logic       busy;
    logic       in_target;
    logic [3:0] poll_limit;
    r = '0;
    busy = (seq_phase == PH_PULSE) || (seq_phase == PH_POLL);
    if (!busy) begin
      seq_phase = PH_IDLE;
      if (c.mode == MODE_WAKE || c.mode == MODE_SLEEP) begin
        seq_to_sleep = (c.mode == MODE_SLEEP);
        // The module already sits in the requested state.
        if (seq_to_sleep == !c.awake_level) begin
          r.done_res = 1'b1;
        end else begin
          seq_attempts = '0;
          seq_polls    = '0;
          start_pulse();
        end
      end
    end else if (c.mode == MODE_TICK) begin
      if (seq_phase == PH_PULSE) begin
        seq_pulses = seq_pulses + 4'd1;
        if (seq_pulses == 4'd0 || seq_pulses >= count_limit(reg_pulse_ticks)) begin
          seq_power = 1'b0;
          seq_polls = '0;
          seq_phase = PH_POLL;
        end
      end else begin
        poll_limit = count_limit(seq_to_sleep ? reg_sleep_polls : reg_wake_polls);
        seq_polls  = seq_polls + 4'd1;
        in_target  = (seq_to_sleep == !c.awake_level);
        if (in_target) begin
          seq_phase  = PH_IDLE;
          r.done_res = 1'b1;
        end else if (seq_polls == 4'd0 || seq_polls >= poll_limit) begin
          if (seq_to_sleep) begin
            seq_phase  = PH_IDLE;
            r.done_res = 1'b1;
            r.status   = 1'b1;
          end else begin
            seq_attempts = seq_attempts + 3'd1;
            if (seq_attempts != 3'd0 && seq_attempts < attempt_limit(reg_attempts)) begin
              seq_polls = '0;
              start_pulse();
            end else begin
              seq_phase  = PH_IDLE;
              r.done_res = 1'b1;
              r.status   = 1'b1;
            end
          end
        end
      end
    end
    r.power_pin = seq_power;
    r.busy_res  = (seq_phase == PH_PULSE) || (seq_phase == PH_POLL);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) begin
      $display("ERROR at cycle %0d: %s", cycle_count, what);
    end
    mismatch_count++;
  endtask

  // Result receiver: random stall bursts while idling is allowed.
  initial begin
    forever begin
      @(posedge clk);
      if (receiver_idles && $urandom_range(0, 5) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      res_ready <= 1'b1;
    end
  end

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat %b with nothing pending", res));
      end else begin
        want = pending_results.pop_front();
        if (res.power_pin !== want.power_pin)
          report_mismatch($sformatf("power_pin %b, predicted %b", res.power_pin, want.power_pin));
        if (res.busy_res !== want.busy_res)
          report_mismatch($sformatf("busy_res %b, predicted %b", res.busy_res, want.busy_res));
        if (res.done_res !== want.done_res)
          report_mismatch($sformatf("done_res %b, predicted %b", res.done_res, want.done_res));
        if (res.status !== want.status)
          report_mismatch($sformatf("status %b, predicted %b", res.status, want.status));
      end
    end
  end

  // Send one event beat, wait for its acceptance and queue the predicted result.
  task automatic send_event(input cmd_t c, output res_t predicted);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!cmd_ready);
    predicted = sequencer_step(c);
    pending_results.push_back(predicted);
  endtask

  task automatic send_directed(input logic [1:0] mode, input logic awake);
    cmd_t c;
    res_t r;
    c.mode        = mode;
    c.awake_level = awake;
    send_event(c, r);
  endtask

  // Stop sending and let every outstanding result drain.
  task automatic wait_quiet();
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_WAKE_ATTEMPTS: reg_attempts    = data[2:0];
      CFG_WAKE_POLLS:    reg_wake_polls  = data;
      CFG_SLEEP_POLLS:   reg_sleep_polls = data;
      CFG_PULSE_TICKS:   reg_pulse_ticks = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [3:0] attempts, input logic [3:0] wake_polls,
                               input logic [3:0] sleep_polls, input logic [3:0] pulse_ticks);
    wait_quiet();
    write_reg(CFG_WAKE_ATTEMPTS, attempts);
    write_reg(CFG_WAKE_POLLS, wake_polls);
    write_reg(CFG_SLEEP_POLLS, sleep_polls);
    write_reg(CFG_PULSE_TICKS, pulse_ticks);
  endtask

  // Mostly complete wake and sleep sequences with a random response time of the
  // awake pin, mixed with stray commands, no-event beats and pin glitches.
  task automatic run_sequences(input int unsigned n_items);
    int unsigned sent;
    int unsigned respond_at;
    int unsigned ticks;
    logic        target;
    cmd_t        c;
    res_t        r;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        c.mode        = 2'($urandom_range(0, 3));
        c.awake_level = 1'($urandom_range(0, 1));
        send_event(c, r);
        sent++;
      end else begin
        c.mode        = $urandom_range(0, 1) ? MODE_WAKE : MODE_SLEEP;
        target        = (c.mode == MODE_WAKE);
        c.awake_level = ($urandom_range(0, 9) == 0) ? target : !target;
        respond_at    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 240)
                                                    : $urandom_range(0, 30);
        send_event(c, r);
        sent++;
        ticks = 0;
        while (r.busy_res && sent < n_items) begin
          c.mode        = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(1, 3)) : MODE_TICK;
          c.awake_level = (ticks >= respond_at) ? target : !target;
          if ($urandom_range(0, 19) == 0) c.awake_level = !c.awake_level;
          send_event(c, r);
          sent++;
          ticks++;
        end
      end
    end
  endtask

  // Reset register values: idle events, instant completions, ignored commands
  // while busy, and a successful wake and sleep.
  task automatic test_reset_defaults();
    send_directed(MODE_TICK, 1'b0);
    send_directed(MODE_NONE, 1'b1);
    send_directed(MODE_WAKE, 1'b1);
    send_directed(MODE_SLEEP, 1'b0);
    send_directed(MODE_WAKE, 1'b0);
    send_directed(MODE_SLEEP, 1'b0);
    send_directed(MODE_NONE, 1'b0);
    send_directed(MODE_TICK, 1'b0);
    send_directed(MODE_TICK, 1'b0);
    send_directed(MODE_TICK, 1'b1);
    send_directed(MODE_SLEEP, 1'b1);
    send_directed(MODE_TICK, 1'b1);
    send_directed(MODE_TICK, 1'b0);
  endtask

  // Zero in every register acts as one: shortest wake and sleep timeouts.
  task automatic test_zero_registers();
    load_settings(4'd0, 4'd0, 4'd0, 4'd0);
    send_directed(MODE_WAKE, 1'b0);
    send_directed(MODE_TICK, 1'b0);
    send_directed(MODE_TICK, 1'b0);
    send_directed(MODE_SLEEP, 1'b1);
    send_directed(MODE_TICK, 1'b1);
    send_directed(MODE_TICK, 1'b1);
  endtask

  // Largest and smallest settings; the attempts value with bit 3 set wraps to 7.
  task automatic test_extreme_settings();
    load_settings(4'd15, 4'd15, 4'd15, 4'd15);
    run_sequences(150);
    load_settings(4'd1, 4'd1, 4'd1, 4'd1);
    run_sequences(150);
  endtask

  task automatic test_random_settings();
    for (int i = 0; i < 4; i++) begin
      sender_idles   = (i != 2);
      receiver_idles = (i != 1);
      load_settings(4'($urandom_range(0, 15)), 4'($urandom_range(0, 6)),
                    4'($urandom_range(0, 6)), 4'($urandom_range(0, 4)));
      run_sequences(150);
    end
  endtask

  // Final stretch at full rate on both sides.
  task automatic test_full_rate();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    load_settings(4'd3, 4'd5, 4'd8, 4'd2);
    run_sequences(200);
  endtask

  initial begin
    sequencer_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_zero_registers();
    test_extreme_settings();
    test_random_settings();
    test_full_rate();
    wait_quiet();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/wss_pkg.sv
src/wss_cfg.sv
src/wss_seq.sv
src/module_wake_sleep_sequencer.sv
sim/testbench.sv
